// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg: shared definitions for the postfix stack calculator
// stack geometry, field widths, op and status codes, alu control structs
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 5;
    localparam int CNT_W       = $clog2(DATA_W);

    // input op codes
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] data;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_FIX
    } t_alu_state;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    function automatic t_alu_op to_alu_op(input logic [OP_W-1:0] op);
        t_alu_op r;
        case (op)
            OP_ADD:  r = ALU_ADD;
            OP_SUB:  r = ALU_SUB;
            OP_MUL:  r = ALU_MUL;
            default: r = ALU_DIV;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/psc_if.sv =====
// ----------------------------------------------------------------------------
// psc_if: valid/ready channels of the postfix stack calculator
// one interface for input items, one for result items
// ----------------------------------------------------------------------------
interface psc_in_if;
    import psc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] operand_value;

    modport source (output valid, output op, output operand_value, input ready);
    modport sink   (input valid, input op, input operand_value, output ready);
endinterface

interface psc_out_if;
    import psc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  stack_depth;

    modport source (output valid, output status, output top_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input top_value, input stack_depth,
                    output ready);
endinterface

// ===== rtl/postfix_stack_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_calculator_unit: reverse polish integer evaluator
// operand stack in ram with a cached top entry, serial arithmetic unit
// ----------------------------------------------------------------------------
// Each input transfer either pushes a signed 32-bit value or applies add,
// subtract, multiply or divide to the two top entries, and every input
// transfer yields exactly one result transfer with status, top of stack and
// depth. Push, underflow and undefined op codes finish at the accepting edge,
// so their result is offered on the next cycle. A binary operator on two or
// more entries passes through the stack ram read of the left operand, the
// one-bit steps of the serial arithmetic unit and a finishing step (sign fix
// of the quotient) before its result is loaded. The unit works on one item at a
// time; the next item is taken once the result register is free or its
// transfer completes in that cycle. The stack needs no clearing after reset:
// only entries below the stack pointer are ever read.
// ----------------------------------------------------------------------------
module postfix_stack_calculator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psc_in_if.sink     i_in,
    psc_out_if.source  o_out
);
    import psc_pkg::*;

    // control and stack state
    t_state              r_state, n_state;
    logic [SP_W-1:0]     r_sp;
    logic [DATA_W-1:0]   r_top;
    logic [DATA_W-1:0]   r_right;
    t_alu_op             r_aop;
    logic                r_divz;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_top;
    logic [SP_W-1:0]     r_out_depth;

    // combinational control
    logic                w_in_ready;
    logic                w_accept;
    logic                w_start_op;
    logic                w_load;
    logic [STATUS_W-1:0] w_ld_status;
    logic [DATA_W-1:0]   w_ld_top;
    logic [SP_W-1:0]     w_ld_depth;
    logic                w_sp_we;
    logic [SP_W-1:0]     w_sp_next;
    logic                w_top_we;
    logic [DATA_W-1:0]   w_top_next;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic [DATA_W-1:0]   w_ram_wdata;
    logic [ADDR_W-1:0]   w_left_addr;
    logic [DATA_W-1:0]   w_ram_rdata;
    logic [DATA_W-1:0]   w_top_cur;
    logic [DATA_W-1:0]   w_result;
    logic                w_full;
    t_alu_req            w_alu_req;
    t_alu_rsp            w_alu_rsp;

    assign w_full      = (r_sp >= SP_W'(STACK_DEPTH));
    assign w_top_cur   = (r_sp == '0) ? '0 : r_top;
    // left operand always sits just below the cached top
    assign w_left_addr = ADDR_W'(r_sp - SP_W'(2));
    assign w_result    = r_divz ? '0 : w_alu_rsp.data;

    assign w_in_ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept    = i_in.valid && w_in_ready;
    // binary operator with both operands present goes to the serial unit
    assign w_start_op  = w_accept && (i_in.op >= OP_ADD) && (i_in.op <= OP_DIV)
                         && (r_sp >= SP_W'(2));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_start_op) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  if (w_alu_rsp.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_load          = 1'b0;
        w_ld_status     = ST_OK;
        w_ld_top        = w_top_cur;
        w_ld_depth      = r_sp;
        w_sp_we         = 1'b0;
        w_sp_next       = r_sp;
        w_top_we        = 1'b0;
        w_top_next      = i_in.operand_value;
        w_ram_we        = 1'b0;
        w_ram_waddr     = w_left_addr;
        w_ram_wdata     = w_result;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_aop;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.op)
                        OP_PUSH: begin
                            w_load = 1'b1;
                            if (w_full) begin
                                // push onto a full stack is dropped
                                w_ld_status = ST_OVER;
                            end else begin
                                w_ram_we    = 1'b1;
                                w_ram_waddr = r_sp[ADDR_W-1:0];
                                w_ram_wdata = i_in.operand_value;
                                w_top_we    = 1'b1;
                                w_sp_we     = 1'b1;
                                w_sp_next   = r_sp + SP_W'(1);
                                w_ld_top    = i_in.operand_value;
                                w_ld_depth  = r_sp + SP_W'(1);
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (r_sp < SP_W'(2)) begin
                                // empty or single entry: right operand lost
                                w_load      = 1'b1;
                                w_ld_status = ST_UNDER;
                                w_ld_top    = '0;
                                w_ld_depth  = '0;
                                w_sp_we     = 1'b1;
                                w_sp_next   = '0;
                            end
                        end
                        default: begin
                            // undefined op: report current stack
                            w_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_alu_req.start = 1'b1;
            end
            S_EXEC: begin
                if (w_alu_rsp.done) begin
                    // two pops and one push: result replaces the left operand
                    w_load      = 1'b1;
                    w_ld_status = r_divz ? ST_DIVZ : ST_OK;
                    w_ld_top    = w_result;
                    w_ld_depth  = r_sp - SP_W'(1);
                    w_ram_we    = 1'b1;
                    w_top_we    = 1'b1;
                    w_top_next  = w_result;
                    w_sp_we     = 1'b1;
                    w_sp_next   = r_sp - SP_W'(1);
                end
            end
            default: w_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_sp_we) begin
                r_sp <= w_sp_next;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_top_we) begin
            r_top <= w_top_next;
        end
        if (w_start_op) begin
            r_right <= r_top;
            r_aop   <= to_alu_op(i_in.op);
            r_divz  <= (i_in.op == OP_DIV) && (r_top == '0);
        end
        if (w_load) begin
            r_out_status <= w_ld_status;
            r_out_top    <= w_ld_top;
            r_out_depth  <= w_ld_depth;
        end
    end

    psc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_left_addr),
        .o_rdata (w_ram_rdata)
    );

    psc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (w_ram_rdata),
        .i_b     (r_right),
        .o_rsp   (w_alu_rsp)
    );

    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.top_value   = r_out_top;
    assign o_out.stack_depth = DEPTH_W'(r_out_depth);

    // stack pointer never passes the stack size
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack size");

    // an operator only runs with both operands on the stack
    a_two_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_EXEC) |-> (r_sp >= SP_W'(2)))
        else $error("operator running with fewer than two entries");

    // the serial unit only finishes while the sequencer waits for it
    a_done_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> (r_state == S_EXEC))
        else $error("alu done outside execute");

    // operator completion leaves one entry fewer
    a_op_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_alu_rsp.done) |=> (r_sp == $past(r_sp) - SP_W'(1)))
        else $error("wrong depth after operator");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_out_valid) |-> o_out.ready)
        else $error("result register overwritten");
endmodule

// ===== rtl/psc_ram.sv =====
// ----------------------------------------------------------------------------
// psc_ram: generic single-write, single-read ram
// registered read data, one write port
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/psc_alu.sv =====
// ----------------------------------------------------------------------------
// psc_alu: serial arithmetic unit
// one bit per cycle add/subtract, shift-add multiply, restoring divide
// ----------------------------------------------------------------------------
module psc_alu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  psc_pkg::t_alu_req         i_req,
    input  logic [psc_pkg::DATA_W-1:0] i_a,
    input  logic [psc_pkg::DATA_W-1:0] i_b,
    output psc_pkg::t_alu_rsp         o_rsp
);
    import psc_pkg::*;

    t_alu_state        r_state, n_state;
    t_alu_op           r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W:0]   r_acc;
    logic              r_carry;
    logic              r_neg;

    logic              w_bb;
    logic              w_sum;
    logic              w_cout;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W-1:0] w_abs_a;
    logic [DATA_W-1:0] w_abs_b;

    assign w_abs_a = i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
    assign w_abs_b = i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;

    // serial adder bit
    assign w_bb   = r_b[0] ^ (r_op == ALU_SUB);
    assign w_sum  = r_a[0] ^ w_bb ^ r_carry;
    assign w_cout = (r_a[0] & w_bb) | (r_a[0] & r_carry) | (w_bb & r_carry);

    // restoring divide step
    assign w_shift = {r_acc[DATA_W-1:0], r_a[DATA_W-1]};
    assign w_trial = w_shift - {1'b0, r_b};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            A_IDLE:  if (i_req.start) n_state = A_RUN;
            A_RUN:   if (r_cnt == '0) n_state = A_FIX;
            A_FIX:   n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rsp.done = 1'b0;
        o_rsp.data = r_acc[DATA_W-1:0];
        case (r_state)
            A_FIX: begin
                o_rsp.done = 1'b1;
                if (r_op == ALU_DIV) begin
                    o_rsp.data = r_neg ? (DATA_W'(0) - r_a) : r_a;
                end
            end
            default: o_rsp.done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == A_IDLE && i_req.start) begin
            r_op    <= i_req.op;
            r_cnt   <= CNT_W'(DATA_W - 1);
            r_acc   <= '0;
            r_carry <= (i_req.op == ALU_SUB);
            r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            if (i_req.op == ALU_DIV) begin
                r_a <= w_abs_a;
                r_b <= w_abs_b;
            end else begin
                r_a <= i_a;
                r_b <= i_b;
            end
        end else if (r_state == A_RUN) begin
            r_cnt <= r_cnt - CNT_W'(1);
            case (r_op)
                ALU_ADD, ALU_SUB: begin
                    r_carry <= w_cout;
                    r_a     <= r_a >> 1;
                    r_b     <= r_b >> 1;
                    r_acc   <= {1'b0, w_sum, r_acc[DATA_W-1:1]};
                end
                ALU_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= {1'b0, r_acc[DATA_W-1:0] + r_a};
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
                default: begin
                    if (!w_trial[DATA_W]) begin
                        r_acc <= w_trial;
                        r_a   <= {r_a[DATA_W-2:0], 1'b1};
                    end else begin
                        r_acc <= w_shift;
                        r_a   <= {r_a[DATA_W-2:0], 1'b0};
                    end
                end
            endcase
        end
    end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for postfix_stack_calculator_unit
// drives push and operator transfers through the input channel, predicts every
// status / top / depth report with a behavioral stack, and compares each
// report transfer in order; a directed table walks the corner cases first,
// then weighted random sequences fill, drain and exercise the arithmetic
// ----------------------------------------------------------------------------
module testbench;
    import psc_pkg::*;

    // op codes the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

    localparam int RANDOM_ITEMS = 900;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no transfer at all
    localparam int SETTLE       = 40;     // idle margin after the last report, longer than the operator path
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
    } t_report;

    // one directed step: op, value, how often, and a hand-written report
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic [4:0]        reps;
        logic              fixed;
        t_report           want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psc_in_if  in_ch ();
    psc_out_if out_ch ();

    postfix_stack_calculator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // directed steps; rows with fixed set carry a report read straight off the rules
    t_row directed_rows [0:DIR_ROWS-1] = '{
        // operators on empty and single-entry stacks underflow
        '{OP_ADD,   32'hffff_ffff, 5'd1,  1'b1, '{ST_UNDER, 32'h0, 5'd0}},
        '{OP_PUSH,  32'h0000_0005, 5'd1,  1'b1, '{ST_OK,    32'h5, 5'd1}},
        '{OP_SUB,   32'h0000_0000, 5'd1,  1'b1, '{ST_UNDER, 32'h0, 5'd0}},
        // max + 1 wraps to the most negative value
        '{OP_PUSH,  VAL_MAX,       5'd1,  1'b1, '{ST_OK,    VAL_MAX, 5'd1}},
        '{OP_PUSH,  32'h0000_0001, 5'd1,  1'b1, '{ST_OK,    32'h1, 5'd2}},
        '{OP_ADD,   32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    VAL_MIN, 5'd1}},
        // most negative / -1 stays most negative
        '{OP_PUSH,  32'hffff_ffff, 5'd1,  1'b1, '{ST_OK,    32'hffff_ffff, 5'd2}},
        '{OP_DIV,   32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    VAL_MIN, 5'd1}},
        // divide by zero leaves a zero
        '{OP_PUSH,  32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    32'h0, 5'd2}},
        '{OP_DIV,   32'h1234_5678, 5'd1,  1'b1, '{ST_DIVZ,  32'h0, 5'd1}},
        // undefined codes change nothing
        '{OP_RSVD5, 32'hdead_beef, 5'd1,  1'b1, '{ST_OK,    32'h0, 5'd1}},
        '{OP_RSVD7, 32'hffff_ffff, 5'd1,  1'b1, '{ST_OK,    32'h0, 5'd1}},
        // 0 - min wraps back to min
        '{OP_PUSH,  VAL_MIN,       5'd1,  1'b1, '{ST_OK,    VAL_MIN, 5'd2}},
        '{OP_SUB,   32'h0000_0000, 5'd1,  1'b1, '{ST_OK,    VAL_MIN, 5'd1}},
        '{OP_PUSH,  32'hffff_fff9, 5'd1,  1'b0, '0},
        '{OP_MUL,   32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_PUSH,  32'h0000_0007, 5'd1,  1'b0, '0},
        '{OP_DIV,   32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_PUSH,  32'hffff_ff9c, 5'd1,  1'b0, '0},
        '{OP_PUSH,  32'h0000_0007, 5'd1,  1'b0, '0},
        '{OP_DIV,   32'h0000_0000, 5'd1,  1'b0, '0},
        // fill to the top, then one push too many
        '{OP_PUSH,  32'h1234_5678, 5'd14, 1'b0, '0},
        '{OP_PUSH,  32'h0000_0001, 5'd1,  1'b1, '{ST_OVER,  32'h1234_5678, 5'd16}},
        '{OP_MUL,   32'h7fff_0000, 5'd1,  1'b0, '0},
        '{OP_RSVD6, 32'h0000_0000, 5'd1,  1'b0, '0}
    };

    // behavioral copy of the operand stack
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                stack_count;
    int                peak_depth;

    t_report awaited_reports [$];

    // hand-written report travelling with the item on the input channel
    logic    row_fixed;
    t_report row_report;

    int items_accepted;
    int reports_checked;
    int mismatches;
    int idle_cycles;
    int n_under;
    int n_divz;
    int n_over;

    // applies one item to the stack copy and returns the report it should cause
    function automatic t_report apply_postfix_step(input logic [OP_W-1:0] op,
                                                   input logic [DATA_W-1:0] value);
        t_report           rep;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] lhs_mag;
        logic [DATA_W-1:0] rhs_mag;
        rep.status = ST_OK;
        if (op == OP_PUSH) begin
            if (stack_count >= STACK_DEPTH) begin
                rep.status = ST_OVER;
            end else begin
                stack_mem[stack_count] = value;
                stack_count++;
            end
        end else if (op <= OP_DIV) begin
            if (stack_count < 2) begin
                // a lone right operand is popped and lost
                stack_count = 0;
                rep.status  = ST_UNDER;
            end else begin
                rhs = stack_mem[stack_count-1];
                lhs = stack_mem[stack_count-2];
                case (op)
                    OP_ADD: res = lhs + rhs;
                    OP_SUB: res = lhs - rhs;
                    OP_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == '0) begin
                            res        = '0;
                            rep.status = ST_DIVZ;
                        end else begin
                            // magnitudes divide unsigned, sign applied after
                            lhs_mag = lhs[DATA_W-1] ? -lhs : lhs;
                            rhs_mag = rhs[DATA_W-1] ? -rhs : rhs;
                            res     = lhs_mag / rhs_mag;
                            if (lhs[DATA_W-1] ^ rhs[DATA_W-1])
                                res = -res;
                        end
                    end
                endcase
                stack_mem[stack_count-2] = res;
                stack_count--;
            end
        end
        if (stack_count > peak_depth)
            peak_depth = stack_count;
        rep.top   = (stack_count == 0) ? '0 : stack_mem[stack_count-1];
        rep.depth = DEPTH_W'(stack_count);
        return rep;
    endfunction

    // transfer monitor: reports are checked before the same edge's item is predicted
    always @(posedge i_clk) begin : transfer_monitor
        t_report want;
        t_report got;
        logic    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                reports_checked++;
                if (awaited_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: report with nothing awaited, status %0d top %h depth %0d",
                             $time, out_ch.status, out_ch.top_value, out_ch.stack_depth);
                end else begin
                    want = awaited_reports.pop_front();
                    case (want.status)
                        ST_UNDER: n_under++;
                        ST_DIVZ:  n_divz++;
                        ST_OVER:  n_over++;
                        default: ;
                    endcase
                    if (out_ch.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_ch.status);
                    end
                    if (out_ch.top_value !== want.top) begin
                        mismatches++;
                        $display("%0t: top_value mismatch, expected %h, actual %h",
                                 $time, want.top, out_ch.top_value);
                    end
                    if (out_ch.stack_depth !== want.depth) begin
                        mismatches++;
                        $display("%0t: stack_depth mismatch, expected %0d, actual %0d",
                                 $time, want.depth, out_ch.stack_depth);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                items_accepted++;
                // the stack copy always advances, even when the row carries its own report
                got = apply_postfix_step(in_ch.op, in_ch.operand_value);
                awaited_reports.push_back(row_fixed ? row_report : got);
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // sender idling: random gaps between items, with stretches of back-to-back items
    bit send_busy_phase;

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                             input logic fixed, input t_report want);
        int gap;
        gap = send_busy_phase ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 29) == 0)
            send_busy_phase = !send_busy_phase;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= op;
        in_ch.operand_value <= value;
        row_fixed           <= fixed;
        row_report          <= want;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
    endtask

    // hold the input side quiet until every awaited report has arrived
    task automatic wait_all_reports();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (awaited_reports.size() != 0);
        @(posedge i_clk);
    endtask

    // report side: ready drops for a random stall ahead of each report
    initial begin : report_sink
        int  stall;
        bit  busy_phase;
        busy_phase   = 1'b0;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = busy_phase ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 29) == 0)
                busy_phase = !busy_phase;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin : stimulus
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        int                mode;
        int                depth_guess;
        int                push_pct;
        stack_count     = 0;
        peak_depth      = 0;
        items_accepted  = 0;
        reports_checked = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        n_under         = 0;
        n_divz          = 0;
        n_over          = 0;
        send_busy_phase = 1'b0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.op            <= OP_PUSH;
        in_ch.operand_value <= '0;
        row_fixed           <= 1'b0;
        row_report          <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk
        foreach (directed_rows[i]) begin
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_item(directed_rows[i].op, directed_rows[i].value,
                          directed_rows[i].fixed, directed_rows[i].want);
        end
        wait_all_reports();

        // random sequences; the mode biases toward filling, draining or balance
        depth_guess = stack_count;
        mode        = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                wait_all_reports();
            if ($urandom_range(0, 24) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                1:       push_pct = 85;
                2:       push_pct = 15;
                default: push_pct = (depth_guess < 2) ? 75 :
                                    (depth_guess >= STACK_DEPTH) ? 30 : 50;
            endcase
            if ($urandom_range(0, 99) < 3)
                op = OP_W'(OP_RSVD5 + $urandom_range(0, 2));
            else if ($urandom_range(0, 99) < push_pct)
                op = OP_PUSH;
            else
                op = OP_W'(OP_ADD + $urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = $urandom_range(0, 16) - 8;   // small, zero divisors
                4: begin
                    case ($urandom_range(0, 4))
                        0:       value = VAL_MIN;
                        1:       value = VAL_MAX;
                        2:       value = '0;
                        3:       value = 32'h1;
                        default: value = '1;
                    endcase
                end
                default: value = $urandom;
            endcase
            // track depth here so the mode weights follow the stack
            if (op == OP_PUSH) begin
                if (depth_guess < STACK_DEPTH)
                    depth_guess++;
            end else if (op <= OP_DIV) begin
                depth_guess = (depth_guess < 2) ? 0 : depth_guess - 1;
            end
            send_item(op, value, 1'b0, '0);
        end
        wait_all_reports();
        repeat (SETTLE) @(posedge i_clk);

        $display("run covered %0d items and %0d reports, stack reached depth %0d",
                 items_accepted, reports_checked, peak_depth);
        $display("special reports: %0d underflow, %0d divide by zero, %0d overflow",
                 n_under, n_divz, n_over);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
